[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the graph walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define AM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define AM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

[hw/rtl/amgw_pkg.sv]
// Package with the types and constants of the adjacency matrix graph walker.
package amgw_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned VTX_W  = 6;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned ARC_W  = 13;
	localparam int unsigned VC_W   = 7;
	localparam int unsigned IN_W   = 16;
	localparam int unsigned OUT_W  = 24;
	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_COUNT  = 3'd2,
		OP_BFS    = 3'd3,
		OP_DFS    = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_UPDATE = 2'd0,
		KIND_VISIT  = 2'd1,
		KIND_COUNT  = 2'd2,
		KIND_RANGE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RS_SRC,
		RS_DST,
		RS_CNT,
		RS_QV,
		RS_SV
	} row_sel_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_UPDATE,
		EM_RANGE,
		EM_COUNT,
		EM_FLUSH
	} emit_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_U_RD1,
		ST_U_WR1,
		ST_U_RD2,
		ST_U_WR2,
		ST_C_RUN,
		ST_C_DRAIN,
		ST_B_INIT,
		ST_B_CHK,
		ST_B_VIS,
		ST_B_LOAD,
		ST_B_PUSH,
		ST_D_INIT,
		ST_D_CHK,
		ST_D_ROW,
		ST_D_STEP,
		ST_E_RANGE,
		ST_E_UPDATE,
		ST_E_COUNT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     row_rd;
		logic     row_wr;
		row_sel_t row_sel;
		logic     cnt_clr;
		logic     q_init;
		logic     q_rd;
		logic     bfs_visit;
		logic     fresh_load;
		logic     fresh_push;
		logic     d_init;
		logic     s_rd;
		logic     d_step;
		emit_t    emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            range_err;
		logic            q_empty;
		logic            sp_zero;
		logic            fresh_nz;
		logic            cnt_done;
		logic            out_free;
	} sts_t;

endpackage

[hw/rtl/amgw_ctrl.sv]
// Controller state machine that sequences updates, counts and searches.
module amgw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  amgw_pkg::sts_t  sts,
	output amgw_pkg::cmd_t  cmd
);

	amgw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amgw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amgw_pkg::ST_IDLE: begin
				if (in_valid) state_d = amgw_pkg::ST_DISPATCH;
			end
			amgw_pkg::ST_DISPATCH: begin
				priority if (sts.range_err) begin
					state_d = amgw_pkg::ST_E_RANGE;
				end else if (sts.op == amgw_pkg::OP_INSERT || sts.op == amgw_pkg::OP_REMOVE) begin
					state_d = amgw_pkg::ST_U_RD1;
				end else if (sts.op == amgw_pkg::OP_COUNT) begin
					state_d = amgw_pkg::ST_C_RUN;
				end else if (sts.op == amgw_pkg::OP_BFS) begin
					state_d = amgw_pkg::ST_B_INIT;
				end else if (sts.op == amgw_pkg::OP_DFS) begin
					state_d = amgw_pkg::ST_D_INIT;
				end else begin
					state_d = amgw_pkg::ST_IDLE;
				end
			end
			amgw_pkg::ST_U_RD1:   state_d = amgw_pkg::ST_U_WR1;
			amgw_pkg::ST_U_WR1:   state_d = amgw_pkg::ST_U_RD2;
			amgw_pkg::ST_U_RD2:   state_d = amgw_pkg::ST_U_WR2;
			amgw_pkg::ST_U_WR2:   state_d = amgw_pkg::ST_E_UPDATE;
			amgw_pkg::ST_C_RUN: begin
				if (sts.cnt_done) state_d = amgw_pkg::ST_C_DRAIN;
			end
			amgw_pkg::ST_C_DRAIN: state_d = amgw_pkg::ST_E_COUNT;
			amgw_pkg::ST_B_INIT:  state_d = amgw_pkg::ST_B_CHK;
			amgw_pkg::ST_B_CHK: begin
				state_d = sts.q_empty ? amgw_pkg::ST_FLUSH : amgw_pkg::ST_B_VIS;
			end
			amgw_pkg::ST_B_VIS: begin
				if (sts.out_free) state_d = amgw_pkg::ST_B_LOAD;
			end
			amgw_pkg::ST_B_LOAD:  state_d = amgw_pkg::ST_B_PUSH;
			amgw_pkg::ST_B_PUSH: begin
				if (!sts.fresh_nz) state_d = amgw_pkg::ST_B_CHK;
			end
			amgw_pkg::ST_D_INIT:  state_d = amgw_pkg::ST_D_CHK;
			amgw_pkg::ST_D_CHK: begin
				state_d = sts.sp_zero ? amgw_pkg::ST_FLUSH : amgw_pkg::ST_D_ROW;
			end
			amgw_pkg::ST_D_ROW:   state_d = amgw_pkg::ST_D_STEP;
			amgw_pkg::ST_D_STEP: begin
				if (sts.out_free) state_d = amgw_pkg::ST_D_CHK;
			end
			amgw_pkg::ST_E_RANGE, amgw_pkg::ST_E_UPDATE, amgw_pkg::ST_E_COUNT,
			amgw_pkg::ST_FLUSH: begin
				if (sts.out_free) state_d = amgw_pkg::ST_IDLE;
			end
			default: state_d = amgw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.row_sel = amgw_pkg::RS_SRC;
		cmd.emit    = amgw_pkg::EM_NONE;
		unique case (state_q)
			amgw_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			amgw_pkg::ST_DISPATCH: begin
				cmd.cnt_clr = (sts.op == amgw_pkg::OP_COUNT);
			end
			amgw_pkg::ST_U_RD1: begin
				cmd.row_rd = 1'b1;
			end
			amgw_pkg::ST_U_WR1: begin
				cmd.row_wr = 1'b1;
			end
			amgw_pkg::ST_U_RD2: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = amgw_pkg::RS_DST;
			end
			amgw_pkg::ST_U_WR2: begin
				cmd.row_wr  = 1'b1;
				cmd.row_sel = amgw_pkg::RS_DST;
			end
			amgw_pkg::ST_C_RUN: begin
				cmd.row_rd  = !sts.cnt_done;
				cmd.row_sel = amgw_pkg::RS_CNT;
			end
			amgw_pkg::ST_B_INIT: cmd.q_init = 1'b1;
			amgw_pkg::ST_B_CHK:  cmd.q_rd   = !sts.q_empty;
			amgw_pkg::ST_B_VIS: begin
				cmd.bfs_visit = sts.out_free;
				cmd.row_rd    = sts.out_free;
				cmd.row_sel   = amgw_pkg::RS_QV;
			end
			amgw_pkg::ST_B_LOAD: cmd.fresh_load = 1'b1;
			amgw_pkg::ST_B_PUSH: cmd.fresh_push = sts.fresh_nz;
			amgw_pkg::ST_D_INIT: cmd.d_init = 1'b1;
			amgw_pkg::ST_D_CHK:  cmd.s_rd   = !sts.sp_zero;
			amgw_pkg::ST_D_ROW: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = amgw_pkg::RS_SV;
			end
			amgw_pkg::ST_D_STEP: cmd.d_step = sts.out_free;
			amgw_pkg::ST_E_RANGE: begin
				if (sts.out_free) cmd.emit = amgw_pkg::EM_RANGE;
			end
			amgw_pkg::ST_E_UPDATE: begin
				if (sts.out_free) cmd.emit = amgw_pkg::EM_UPDATE;
			end
			amgw_pkg::ST_E_COUNT: begin
				if (sts.out_free) cmd.emit = amgw_pkg::EM_COUNT;
			end
			amgw_pkg::ST_FLUSH: begin
				if (sts.out_free) cmd.emit = amgw_pkg::EM_FLUSH;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/amgw_dp.sv]
// Datapath with the adjacency memory, queue, stack, counters and result register.
module amgw_dp #(
	parameter int unsigned MAX_VERTICES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [amgw_pkg::IN_W-1:0]     in_data,
	input  logic                          cfg_we,
	input  logic [amgw_pkg::VC_W-1:0]     cfg_wdata,
	input  amgw_pkg::cmd_t                cmd,
	output amgw_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [amgw_pkg::OUT_W-1:0]    out_data,
	output logic [amgw_pkg::KIND_W-1:0]   out_kind,
	output logic                          out_last
);

	localparam int unsigned MV = MAX_VERTICES;
	localparam int unsigned VW = $clog2(MV);
	localparam int unsigned CW = $clog2(MV + 1);
	localparam int unsigned NW = amgw_pkg::VC_W;

	function automatic logic [VW-1:0] lowest(input logic [MV-1:0] x);
		logic [VW-1:0] idx;
		idx = '0;
		for (int i = MV - 1; i >= 0; i--) begin
			if (x[i]) idx = VW'(i);
		end
		return idx;
	endfunction

	function automatic logic [MV-1:0] onehot(input logic [VW-1:0] k);
		return {{(MV-1){1'b0}}, 1'b1} << k;
	endfunction

	// Latched request and configuration.
	logic [NW-1:0]                 vc_q;
	logic [amgw_pkg::OP_W-1:0]     op_q;
	logic [amgw_pkg::VTX_W-1:0]    src_q, dst_q;
	logic                          both_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= amgw_pkg::VC_RESET;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= in_data[2:0];
			src_q  <= in_data[8:3];
			dst_q  <= in_data[14:9];
			both_q <= in_data[15];
		end
	end

	logic [NW-1:0] n;
	logic [MV-1:0] cmask;
	logic          src_big, dst_big;

	assign n       = (vc_q > NW'(MV)) ? NW'(MV) : vc_q;
	assign src_big = (NW'(src_q) >= n);
	assign dst_big = (NW'(dst_q) >= n);

	always_comb begin
		for (int i = 0; i < MV; i++) begin
			cmask[i] = (NW'(i) < n);
		end
	end

	logic range_err;
	always_comb begin
		unique case (op_q)
			amgw_pkg::OP_INSERT, amgw_pkg::OP_REMOVE: range_err = src_big || dst_big;
			amgw_pkg::OP_BFS:                         range_err = (n == '0);
			amgw_pkg::OP_DFS:                         range_err = src_big;
			default:                                  range_err = 1'b0;
		endcase
	end

	// Adjacency rows; a row never written reads as zero through its valid bit.
	logic [MV-1:0] adj_mem [MV];
	logic [MV-1:0] row_vld_q;
	logic [MV-1:0] row_q;
	logic          rd_vld_q;
	logic [MV-1:0] row_data;
	logic [VW-1:0] row_addr;
	logic [VW-1:0] wr_bit;
	logic [MV-1:0] wr_data;

	logic [VW-1:0] q_rd_q, s_rd_q;
	logic [CW-1:0] cnt_idx_q;

	always_comb begin
		unique case (cmd.row_sel)
			amgw_pkg::RS_SRC: row_addr = src_q[VW-1:0];
			amgw_pkg::RS_DST: row_addr = dst_q[VW-1:0];
			amgw_pkg::RS_CNT: row_addr = cnt_idx_q[VW-1:0];
			amgw_pkg::RS_QV:  row_addr = q_rd_q;
			amgw_pkg::RS_SV:  row_addr = s_rd_q;
			default:          row_addr = '0;
		endcase
	end

	assign row_data = rd_vld_q ? row_q : '0;
	assign wr_bit   = (cmd.row_sel == amgw_pkg::RS_SRC) ? dst_q[VW-1:0] : src_q[VW-1:0];
	assign wr_data  = (op_q == amgw_pkg::OP_INSERT) ? (row_data | onehot(wr_bit))
	                                                : (row_data & ~onehot(wr_bit));

	always_ff @(posedge clk) begin
		if (cmd.row_wr) adj_mem[row_addr] <= wr_data;
		if (cmd.row_rd) row_q <= adj_mem[row_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.row_wr) row_vld_q[row_addr] <= 1'b1;
			if (cmd.row_rd) rd_vld_q <= row_vld_q[row_addr];
		end
	end

	// Count: one row read per cycle, its population added in the cycle after the read.
	logic                       cnt_s1;
	logic [amgw_pkg::ARC_W-1:0] acc_q;
	logic [CW-1:0]              pop;
	logic                       cnt_rd;

	assign cnt_rd = cmd.row_rd && (cmd.row_sel == amgw_pkg::RS_CNT);

	always_comb begin
		pop = '0;
		for (int i = 0; i < MV; i++) begin
			pop = pop + CW'(row_data[i] & cmask[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_idx_q <= '0;
			cnt_s1    <= 1'b0;
			acc_q     <= '0;
		end else begin
			cnt_s1 <= cnt_rd;
			if (cmd.cnt_clr) begin
				cnt_idx_q <= '0;
				acc_q     <= '0;
			end else begin
				if (cnt_rd) cnt_idx_q <= cnt_idx_q + 1'b1;
				if (cnt_s1) acc_q <= acc_q + amgw_pkg::ARC_W'(pop);
			end
		end
	end

	// Search state: visited marks, frontier queue, walk stack, pending vertex.
	logic [VW-1:0] q_mem [MV];
	logic [VW-1:0] s_mem [MV];
	logic [MV-1:0] vis_q, fresh_q, cand;
	logic [CW-1:0] head_q, tail_q, sp_q;
	logic [VW-1:0] pend_q;
	logic          pend_vld_q;
	logic [VW-1:0] fresh_j, cand_j;
	logic          cand_take;
	logic [CW-1:0] sp_top;

	assign fresh_j   = lowest(fresh_q);
	assign cand      = row_data & cmask & ~vis_q;
	assign cand_j    = lowest(cand);
	assign cand_take = (cand != '0) && (sp_q < CW'(MV));
	assign sp_top    = sp_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.q_init) q_mem[0] <= '0;
		else if (cmd.fresh_push) q_mem[tail_q[VW-1:0]] <= fresh_j;
		if (cmd.q_rd) q_rd_q <= q_mem[head_q[VW-1:0]];
		if (cmd.d_init) s_mem[0] <= src_q[VW-1:0];
		else if (cmd.d_step && cand_take) s_mem[sp_q[VW-1:0]] <= cand_j;
		if (cmd.s_rd) s_rd_q <= s_mem[sp_top[VW-1:0]];
		if (cmd.bfs_visit) pend_q <= q_rd_q;
		else if (cmd.d_init) pend_q <= src_q[VW-1:0];
		else if (cmd.d_step && cand_take) pend_q <= cand_j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q      <= '0;
			fresh_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			sp_q       <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cmd.q_init) begin
				vis_q      <= {{(MV-1){1'b0}}, 1'b1};
				head_q     <= '0;
				tail_q     <= CW'(1);
				pend_vld_q <= 1'b0;
			end
			if (cmd.q_rd) head_q <= head_q + 1'b1;
			if (cmd.bfs_visit) pend_vld_q <= 1'b1;
			if (cmd.fresh_load) begin
				fresh_q <= row_data & cmask & ~vis_q;
				vis_q   <= vis_q | (row_data & cmask);
			end
			if (cmd.fresh_push) begin
				fresh_q <= fresh_q & (fresh_q - 1'b1);
				tail_q  <= tail_q + 1'b1;
			end
			if (cmd.d_init) begin
				vis_q      <= onehot(src_q[VW-1:0]);
				sp_q       <= CW'(1);
				pend_vld_q <= 1'b1;
			end
			if (cmd.d_step) begin
				if (cand_take) begin
					vis_q <= vis_q | onehot(cand_j);
					sp_q  <= sp_q + 1'b1;
				end else begin
					sp_q <= sp_top;
				end
			end
		end
	end

	// Result register; the pending vertex leaves when a newer one replaces it or at the final flush.
	logic                          emit_visit;
	logic                          out_valid_q;
	logic [amgw_pkg::KIND_W-1:0]   kind_q;
	logic [amgw_pkg::VTX_W-1:0]    vtx_q;
	logic [amgw_pkg::ARC_W-1:0]    tot_q;
	logic                          last_q;

	assign emit_visit = (cmd.bfs_visit && pend_vld_q) || (cmd.d_step && cand_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_visit || cmd.emit != amgw_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_visit) begin
			kind_q <= amgw_pkg::KIND_VISIT;
			vtx_q  <= amgw_pkg::VTX_W'(pend_q);
			tot_q  <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (cmd.emit)
				amgw_pkg::EM_UPDATE: begin
					kind_q <= amgw_pkg::KIND_UPDATE;
					vtx_q  <= '0;
					tot_q  <= '0;
					last_q <= 1'b1;
				end
				amgw_pkg::EM_RANGE: begin
					kind_q <= amgw_pkg::KIND_RANGE;
					vtx_q  <= '0;
					tot_q  <= '0;
					last_q <= 1'b1;
				end
				amgw_pkg::EM_COUNT: begin
					kind_q <= amgw_pkg::KIND_COUNT;
					vtx_q  <= '0;
					tot_q  <= both_q ? acc_q : (acc_q >> 1);
					last_q <= 1'b1;
				end
				amgw_pkg::EM_FLUSH: begin
					kind_q <= amgw_pkg::KIND_VISIT;
					vtx_q  <= amgw_pkg::VTX_W'(pend_q);
					tot_q  <= '0;
					last_q <= 1'b1;
				end
				default: begin
					kind_q <= kind_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {5'd0, tot_q, vtx_q};

	assign sts.op        = op_q;
	assign sts.range_err = range_err;
	assign sts.q_empty   = (head_q == tail_q);
	assign sts.sp_zero   = (sp_q == '0);
	assign sts.fresh_nz  = (fresh_q != '0);
	assign sts.cnt_done  = (NW'(cnt_idx_q) >= n);
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

[hw/rtl/adjacency_matrix_graph_walker.sv]
// Top level of the adjacency matrix graph walker: controller, datapath and checks.
// Insert or remove reads and rewrites the source row, then the destination row; a count reads every row below n.
// Breadth-first search takes a vertex from the queue, reads its row and queues its unvisited neighbors one by one;
// depth-first search reads the row at the stack top, then pushes one unvisited neighbor or pops the vertex.
// One item is worked on at a time; the next is accepted once its last result is registered.
// Reset clears the graph through per-row valid bits at once and sets vertex_count to 64.
`include "assert_macros.svh"

module adjacency_matrix_graph_walker #(
	parameter int unsigned MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request items; s_tdata from bit 0: opcode[2:0], source_vertex[8:3],
	// destination_vertex[14:9], count_both_directions[15].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// Result items; m_tdata from bit 0: visited_vertex[5:0], arc_total[18:6], zero fill.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	// m_tuser holds result_kind[1:0].
	output logic [1:0]  m_tuser,
	// m_tlast holds last_of_run.
	output logic        m_tlast,
	// Write port of vertex_count.
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	// The controller only issues commands and holds its state; all other storage sits in the datapath.
	amgw_pkg::cmd_t cmd;
	amgw_pkg::sts_t sts;

	amgw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the result register, so the request side is free again
	// while a finished result still waits for m_tready.
	amgw_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

	// An accepted request keeps the request side closed in the following cycle.
	`AM_ASSERT_NXT(a_accept_closes, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Every result other than a visited vertex is the only one of its request.
	`AM_ASSERT_IMP(a_single_last, clk, arst_n, m_tvalid && m_tuser != amgw_pkg::KIND_VISIT, m_tlast)
	// The vertex field is zero unless a vertex is reported.
	`AM_ASSERT_IMP(a_vertex_zero, clk, arst_n, m_tvalid && m_tuser != amgw_pkg::KIND_VISIT, m_tdata[5:0] == 6'd0)
	// The arc total is zero unless a count is reported.
	`AM_ASSERT_IMP(a_total_zero, clk, arst_n, m_tvalid && m_tuser != amgw_pkg::KIND_COUNT, m_tdata[18:6] == 13'd0)

endmodule
